/* sv/tcsb_pkg.sv */
// Shared types and constants of the two-channel spatial binning block.
`default_nettype none

package tcsb_pkg;

    // Width of the per-channel bin sums; sums wrap modulo two to this power.
    localparam int ACC_BITS      = 32;
    // Width of the bin coordinates on the result side.
    localparam int OUT_IDX_BITS  = 10;
    // Configuration port.
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_ADDR_BITS = 2;
    localparam int FRAME_BITS    = 11;
    localparam int BIN_BITS      = 5;

    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BIN_FACTOR   = 2'd2;

    // Register reset values as the raw register contents.
    localparam int FRAME_RESET = 1024;
    localparam int BIN_RESET   = 1;

    // Result queue.
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = 2;
    localparam int OUTQ_CNT_BITS = 3;

    // Result tdata: x_sum, y_sum, bin_column, bin_row, padded to whole bytes.
    localparam int OUT_TDATA_BITS = 88;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - 2 * ACC_BITS - 2 * OUT_IDX_BITS;

    // Per-pixel control from the position tracker to the accumulator.
    typedef struct packed {
        logic active;      // pixel lies inside a whole bin
        logic first_col;   // first column of its bin
        logic col_end;     // last column of its bin
        logic row_first;   // first row of its bin
        logic row_last;    // last row of its bin
        logic last_frame;  // bin is the last one of the binned frame
    } tcsb_ctl_t;

    // One result item.
    typedef struct packed {
        logic                    last;
        logic [OUT_IDX_BITS-1:0] bin_row;
        logic [OUT_IDX_BITS-1:0] bin_col;
        logic [ACC_BITS-1:0]     y_sum;
        logic [ACC_BITS-1:0]     x_sum;
    } tcsb_res_t;

endpackage

`default_nettype wire

/* sv/tcsb_pos.sv */
// Configuration registers, raster position counters and their realignment divider.
`default_nettype none

module tcsb_pos #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BIN   = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tcsb_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [tcsb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                               adv,
    input  wire logic                               sof,
    output tcsb_pkg::tcsb_ctl_t                     ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]            bin_col,
    output logic [$clog2(MAX_WIDTH)-1:0]            bin_row,
    output logic                                    ready
);
    import tcsb_pkg::*;

    localparam int PBITS   = $clog2(MAX_WIDTH);
    localparam int WBITS   = $clog2(MAX_WIDTH + 1);
    localparam int EBITS   = WBITS + 1;
    localparam int NBITS   = $clog2(MAX_BIN + 1);
    localparam int RBITS   = $clog2(MAX_BIN);
    localparam int CBITS   = $clog2(PBITS + 1);
    localparam int W_RESET = (MAX_WIDTH < FRAME_RESET) ? MAX_WIDTH : FRAME_RESET;
    localparam int N_RESET = (MAX_BIN < BIN_RESET) ? MAX_BIN : BIN_RESET;

    function automatic logic [WBITS-1:0] clamp_dim(input logic [FRAME_BITS-1:0] v);
        logic [WBITS-1:0] r;
        if (v == '0)
            r = WBITS'(1);
        else if (int'(v) > MAX_WIDTH)
            r = WBITS'(MAX_WIDTH);
        else
            r = WBITS'(v);
        return r;
    endfunction

    function automatic logic [NBITS-1:0] clamp_bin(input logic [BIN_BITS-1:0] v);
        logic [NBITS-1:0] r;
        if (v == '0)
            r = NBITS'(1);
        else if (int'(v) > MAX_BIN)
            r = NBITS'(MAX_BIN);
        else
            r = NBITS'(v);
        return r;
    endfunction

    logic [WBITS-1:0] w_reg, h_reg;
    logic [NBITS-1:0] n_reg;
    logic [PBITS-1:0] pcol_reg, prow_reg, bcol_reg, brow_reg;
    logic [RBITS-1:0] wbc_reg, wbr_reg;
    logic             busy_reg;
    logic [CBITS-1:0] cnt_reg;
    logic [PBITS-1:0] dcol_reg, drow_reg;
    logic [NBITS-1:0] rcol_reg, rrow_reg;

    logic [PBITS-1:0] cur_pcol, cur_prow, cur_bcol, cur_brow, scol, srow;
    logic [RBITS-1:0] cur_wbc, cur_wbr;
    logic [NBITS-1:0] n_m1;
    logic [EBITS-1:0] n_e, w_e, h_e, scol_e, srow_e;
    logic             col_end, row_end, in_col, in_row, last_col, last_row;
    logic             col_wrap, row_wrap;

    logic [NBITS:0]   rc_sh, rr_sh;
    logic             c_ge, r_ge;
    logic [NBITS-1:0] rc_new, rr_new;
    logic [PBITS-1:0] dcol_next, drow_next;

    // Start of frame forces the position to the frame origin before use.
    assign cur_pcol = sof ? '0 : pcol_reg;
    assign cur_prow = sof ? '0 : prow_reg;
    assign cur_bcol = sof ? '0 : bcol_reg;
    assign cur_brow = sof ? '0 : brow_reg;
    assign cur_wbc  = sof ? '0 : wbc_reg;
    assign cur_wbr  = sof ? '0 : wbr_reg;

    assign n_m1    = n_reg - NBITS'(1);
    assign col_end = (NBITS'(cur_wbc) == n_m1);
    assign row_end = (NBITS'(cur_wbr) == n_m1);

    // A bin is whole when its first pixel plus N stays within the frame;
    // it is the last whole bin when a further bin would not fit.
    assign scol   = cur_pcol - PBITS'(cur_wbc);
    assign srow   = cur_prow - PBITS'(cur_wbr);
    assign n_e    = EBITS'(n_reg);
    assign w_e    = EBITS'(w_reg);
    assign h_e    = EBITS'(h_reg);
    assign scol_e = EBITS'(scol);
    assign srow_e = EBITS'(srow);
    assign in_col   = (scol_e + n_e) <= w_e;
    assign in_row   = (srow_e + n_e) <= h_e;
    assign last_col = (scol_e + n_e + n_e) > w_e;
    assign last_row = (srow_e + n_e + n_e) > h_e;

    assign ctl.active     = in_col && in_row;
    assign ctl.first_col  = (cur_wbc == '0);
    assign ctl.col_end    = col_end;
    assign ctl.row_first  = (cur_wbr == '0);
    assign ctl.row_last   = row_end;
    assign ctl.last_frame = last_col && last_row;
    assign bin_col = cur_bcol;
    assign bin_row = cur_brow;
    assign ready   = !busy_reg;

    assign col_wrap = (EBITS'(cur_pcol) + EBITS'(1)) >= w_e;
    assign row_wrap = (EBITS'(cur_prow) + EBITS'(1)) >= h_e;

    // One restoring division step per cycle on column and row together.
    assign rc_sh     = {rcol_reg, dcol_reg[PBITS-1]};
    assign rr_sh     = {rrow_reg, drow_reg[PBITS-1]};
    assign c_ge      = rc_sh >= {1'b0, n_reg};
    assign r_ge      = rr_sh >= {1'b0, n_reg};
    assign rc_new    = c_ge ? NBITS'(rc_sh - {1'b0, n_reg}) : NBITS'(rc_sh);
    assign rr_new    = r_ge ? NBITS'(rr_sh - {1'b0, n_reg}) : NBITS'(rr_sh);
    assign dcol_next = {dcol_reg[PBITS-2:0], c_ge};
    assign drow_next = {drow_reg[PBITS-2:0], r_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= WBITS'(W_RESET);
            h_reg    <= WBITS'(W_RESET);
            n_reg    <= NBITS'(N_RESET);
            pcol_reg <= '0;
            prow_reg <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
            wbc_reg  <= '0;
            wbr_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            dcol_reg <= '0;
            drow_reg <= '0;
            rcol_reg <= '0;
            rrow_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  w_reg <= clamp_dim(cfg_wdata[FRAME_BITS-1:0]);
                REG_FRAME_HEIGHT: h_reg <= clamp_dim(cfg_wdata[FRAME_BITS-1:0]);
                REG_BIN_FACTOR:   n_reg <= clamp_bin(cfg_wdata[BIN_BITS-1:0]);
                default:          ;
            endcase
            busy_reg <= 1'b1;
            cnt_reg  <= CBITS'(PBITS);
            dcol_reg <= pcol_reg;
            drow_reg <= prow_reg;
            rcol_reg <= '0;
            rrow_reg <= '0;
        end
        else if (busy_reg)
        begin
            dcol_reg <= dcol_next;
            drow_reg <= drow_next;
            rcol_reg <= rc_new;
            rrow_reg <= rr_new;
            cnt_reg  <= cnt_reg - CBITS'(1);
            if (cnt_reg == CBITS'(1))
            begin
                busy_reg <= 1'b0;
                wbc_reg  <= RBITS'(rc_new);
                wbr_reg  <= RBITS'(rr_new);
                bcol_reg <= dcol_next;
                brow_reg <= drow_next;
            end
        end
        else if (adv)
        begin
            if (col_wrap)
            begin
                pcol_reg <= '0;
                wbc_reg  <= '0;
                bcol_reg <= '0;
                if (row_wrap)
                begin
                    prow_reg <= '0;
                    wbr_reg  <= '0;
                    brow_reg <= '0;
                end
                else
                begin
                    prow_reg <= cur_prow + PBITS'(1);
                    wbr_reg  <= row_end ? '0 : cur_wbr + RBITS'(1);
                    brow_reg <= cur_brow + PBITS'(row_end);
                end
            end
            else
            begin
                pcol_reg <= cur_pcol + PBITS'(1);
                wbc_reg  <= col_end ? '0 : cur_wbc + RBITS'(1);
                bcol_reg <= cur_bcol + PBITS'(col_end);
                prow_reg <= cur_prow;
                wbr_reg  <= cur_wbr;
                brow_reg <= cur_brow;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/tcsb_accum.sv */
// Row partial sums and the column line store with its read-modify-write stage.
`default_nettype none

module tcsb_accum #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic signed [SAMPLE_BITS-1:0]  x_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]  y_sample,
    input  wire tcsb_pkg::tcsb_ctl_t            ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   bin_col,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   bin_row,
    output logic                                push,
    output tcsb_pkg::tcsb_res_t                 res
);
    import tcsb_pkg::*;

    localparam int PBITS = $clog2(MAX_WIDTH);
    localparam int XBITS = PBITS + OUT_IDX_BITS;

    logic [2*ACC_BITS-1:0] line_mem [MAX_WIDTH];

    logic [ACC_BITS-1:0]   rpx_reg, rpy_reg;
    logic                  s1_valid_reg, s1_first_reg, s1_emit_reg, s1_last_reg;
    logic [PBITS-1:0]      s1_col_reg, s1_row_reg;
    logic [ACC_BITS-1:0]   s1_rsx_reg, s1_rsy_reg;
    logic [2*ACC_BITS-1:0] rd_reg;
    logic                  wr_valid_reg;
    logic [PBITS-1:0]      wr_addr_reg;
    logic [2*ACC_BITS-1:0] wr_data_reg;

    logic [ACC_BITS-1:0]   x_ext, y_ext, rsx, rsy, new_x, new_y;
    logic [2*ACC_BITS-1:0] base;
    logic                  hit, issue;
    logic [XBITS-1:0]      col_wide, row_wide;

    assign x_ext = ACC_BITS'(x_sample);
    assign y_ext = ACC_BITS'(y_sample);
    assign rsx   = ctl.first_col ? x_ext : rpx_reg + x_ext;
    assign rsy   = ctl.first_col ? y_ext : rpy_reg + y_ext;
    assign hit   = adv && ctl.active;
    assign issue = hit && ctl.col_end;

    // The entry written in the previous cycle is not yet visible in the read data.
    assign base  = (wr_valid_reg && (wr_addr_reg == s1_col_reg)) ? wr_data_reg : rd_reg;
    assign new_x = s1_first_reg ? s1_rsx_reg : base[ACC_BITS-1:0] + s1_rsx_reg;
    assign new_y = s1_first_reg ? s1_rsy_reg : base[2*ACC_BITS-1:ACC_BITS] + s1_rsy_reg;

    assign col_wide    = XBITS'(s1_col_reg);
    assign row_wide    = XBITS'(s1_row_reg);
    assign push        = s1_valid_reg && s1_emit_reg;
    assign res.x_sum   = new_x;
    assign res.y_sum   = new_y;
    assign res.bin_col = col_wide[OUT_IDX_BITS-1:0];
    assign res.bin_row = row_wide[OUT_IDX_BITS-1:0];
    assign res.last    = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpx_reg      <= '0;
            rpy_reg      <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (hit)
            begin
                rpx_reg <= rsx;
                rpy_reg <= rsy;
            end
            s1_valid_reg <= issue;
            wr_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_col_reg   <= bin_col;
            s1_row_reg   <= bin_row;
            s1_rsx_reg   <= rsx;
            s1_rsy_reg   <= rsy;
            s1_first_reg <= ctl.row_first;
            s1_emit_reg  <= ctl.row_last;
            s1_last_reg  <= ctl.last_frame;
            rd_reg       <= line_mem[bin_col];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {new_y, new_x};
            wr_addr_reg          <= s1_col_reg;
            wr_data_reg          <= {new_y, new_x};
        end
    end

endmodule

`default_nettype wire

/* sv/tcsb_outq.sv */
// Small result queue that decouples the output handshake from the pipeline.
`default_nettype none

module tcsb_outq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire tcsb_pkg::tcsb_res_t                din,
    input  wire logic                               pop,
    output tcsb_pkg::tcsb_res_t                     dout,
    output logic                                    valid,
    output logic [tcsb_pkg::OUTQ_CNT_BITS-1:0]      count
);
    import tcsb_pkg::*;

    tcsb_res_t                q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_BITS-1:0] count_reg;

    assign dout  = q_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_BITS'(1);
            count_reg <= count_reg + OUTQ_CNT_BITS'(push) - OUTQ_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

/* sv/two_channel_spatial_binning.sv */
// Top level of the two-channel spatial binning block.
//
// The block takes a raster-order stream of two-channel pixels (x and y
// samples) and returns, for every whole N by N bin, the per-channel sums
// together with the bin's column and row; columns and rows beyond the last
// whole bin are dropped, and N of 1 passes pixels through. It takes one
// pixel per clock cycle while the result queue has room and no counter
// realignment runs: the column sums live in a line store of MAX_WIDTH
// entries that is read when a pixel closes a bin row segment and written
// back in the following cycle, with the value just written forwarded when
// the same bin column comes round again at once. A result passes through
// the read-modify-write stage and the result queue on its way out, and a
// four-item result queue lets input carry on while the output is stalled.
// Every register write realigns the position counters to the new bin size
// with a shared one-bit-per-cycle divider; s_tready stays low until the
// divider has finished after the last write.
// The line store is never cleared: a bin always starts a fresh column sum
// on its first row, so no clearing pass is needed after reset.
`default_nettype none

module two_channel_spatial_binning #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_BIN     = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    // Pixel input.
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // tdata, lowest bit first: x_sample, y_sample, zero padding.
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
    // tuser: start_of_frame.
    input  wire logic                                          s_tuser,
    // Result output.
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // tdata, lowest bit first: x_sum, y_sum, bin_column, bin_row, zero padding.
    output logic [tcsb_pkg::OUT_TDATA_BITS-1:0]                m_tdata,
    // tlast: last_of_frame.
    output logic                                               m_tlast,
    // Configuration writes.
    input  wire logic                                          cfg_we,
    input  wire logic [tcsb_pkg::CFG_ADDR_BITS-1:0]            cfg_addr,
    input  wire logic [tcsb_pkg::CFG_DATA_BITS-1:0]            cfg_wdata
);
    import tcsb_pkg::*;

    localparam int PBITS = $clog2(MAX_WIDTH);

    logic                            s_accept, m_accept;
    logic                            pos_ready;
    tcsb_ctl_t                       ctl;
    logic [PBITS-1:0]                bin_col, bin_row;
    logic                            push;
    tcsb_res_t                       res, q_out;
    logic [OUTQ_CNT_BITS-1:0]        q_count;
    logic [OUTQ_CNT_BITS:0]          q_claim;
    logic signed [SAMPLE_BITS-1:0]   x_in, y_in;

    assign x_in = s_tdata[SAMPLE_BITS-1:0];
    assign y_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // A taken pixel is pushed into the queue in the following cycle, so room is
    // counted against what is queued plus the result about to be pushed.
    assign q_claim  = (OUTQ_CNT_BITS+1)'(q_count) + (OUTQ_CNT_BITS+1)'(push);
    assign s_tready = pos_ready && (q_claim < (OUTQ_CNT_BITS+1)'(OUTQ_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    tcsb_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .adv       (s_accept),
        .sof       (s_tuser),
        .ctl       (ctl),
        .bin_col   (bin_col),
        .bin_row   (bin_row),
        .ready     (pos_ready)
    );

    tcsb_accum #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (s_accept),
        .x_sample (x_in),
        .y_sample (y_in),
        .ctl      (ctl),
        .bin_col  (bin_col),
        .bin_row  (bin_row),
        .push     (push),
        .res      (res)
    );

    tcsb_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (res),
        .pop   (m_accept),
        .dout  (q_out),
        .valid (m_tvalid),
        .count (q_count)
    );

    assign m_tdata = {{OUT_PAD_BITS{1'b0}}, q_out.bin_row, q_out.bin_col,
                      q_out.y_sum, q_out.x_sum};
    assign m_tlast = q_out.last;

    // The queue must never be pushed when full unless an item leaves.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !m_accept) |-> (q_count < OUTQ_CNT_BITS'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // A result only follows a pixel taken in the cycle before.
    a_push_cause: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(s_accept))
        else $error("result without a preceding pixel");

    // A register write stops input while the counters are realigned.
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("pixel taken during counter realignment");

endmodule

`default_nettype wire

/* tb/sv/two_channel_spatial_binning_checker.sv */
// Checker for the two-channel spatial binning block: predicts and compares results.
`default_nettype none

module two_channel_spatial_binning_checker #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_BIN     = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     s_tvalid,
    input  wire logic                                     s_tready,
    // tdata, lowest bit first: x_sample, y_sample, zero padding.
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    // tuser: start_of_frame.
    input  wire logic                                     s_tuser,
    input  wire logic                                     m_tvalid,
    input  wire logic                                     m_tready,
    // tdata, lowest bit first: x_sum, y_sum, bin_column, bin_row, zero padding.
    input  wire logic [tcsb_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
    // tlast: last_of_frame.
    input  wire logic                                     m_tlast,
    input  wire logic                                     cfg_we,
    input  wire logic [tcsb_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  wire logic [tcsb_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
    output int                                            fail_count,
    output int                                            pending,
    output int                                            results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    logic [FRAME_BITS-1:0] width_reg;
    logic [FRAME_BITS-1:0] height_reg;
    logic [BIN_BITS-1:0]   bin_reg;

    // Column sums of the current bin row; deliberately left unset so that a
    // read of a never-written entry shows up as a mismatch.
    logic [ACC_BITS-1:0]   column_x [MAX_WIDTH];
    logic [ACC_BITS-1:0]   column_y [MAX_WIDTH];
    logic [ACC_BITS-1:0]   segment_x;
    logic [ACC_BITS-1:0]   segment_y;
    int unsigned           at_column;
    int unsigned           at_row;

    tcsb_res_t             awaited_bins [$];

    function automatic int unsigned effective(int unsigned raw, int unsigned hi);
        return (raw == 0) ? 1 : ((raw > hi) ? hi : raw);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Adds one pixel to the running sums and queues a bin when it closes.
    task automatic bin_pixel(input logic [SAMPLE_BITS-1:0] xs,
                             input logic [SAMPLE_BITS-1:0] ys,
                             input logic sof);
        int unsigned w, h, n, bins_x, bins_y, bc, br, wc, wr;
        logic [ACC_BITS-1:0] xe, ye;
        tcsb_res_t done;
        w = effective(width_reg, MAX_WIDTH);
        h = effective(height_reg, MAX_WIDTH);
        n = effective(bin_reg, MAX_BIN);
        bins_x = w / n;
        bins_y = h / n;
        xe = {{(ACC_BITS-SAMPLE_BITS){xs[SAMPLE_BITS-1]}}, xs};
        ye = {{(ACC_BITS-SAMPLE_BITS){ys[SAMPLE_BITS-1]}}, ys};
        if (sof)
        begin
            at_column = 0;
            at_row = 0;
        end
        wc = at_column % n;
        wr = at_row % n;
        bc = at_column / n;
        br = at_row / n;
        if (bc < bins_x && br < bins_y)
        begin
            if (wc == 0)
            begin
                segment_x = xe;
                segment_y = ye;
            end
            else
            begin
                segment_x += xe;
                segment_y += ye;
            end
            if (wc == n - 1)
            begin
                if (wr == 0)
                begin
                    column_x[bc] = segment_x;
                    column_y[bc] = segment_y;
                end
                else
                begin
                    column_x[bc] += segment_x;
                    column_y[bc] += segment_y;
                end
                if (wr == n - 1)
                begin
                    done.x_sum   = column_x[bc];
                    done.y_sum   = column_y[bc];
                    done.bin_col = OUT_IDX_BITS'(bc);
                    done.bin_row = OUT_IDX_BITS'(br);
                    done.last    = (bc == bins_x - 1) && (br == bins_y - 1);
                    awaited_bins.push_back(done);
                end
            end
        end
        // The frame wraps to the origin after its last pixel.
        at_column++;
        if (at_column >= w)
        begin
            at_column = 0;
            at_row++;
            if (at_row >= h)
                at_row = 0;
        end
    endtask

    task automatic compare_bin();
        tcsb_res_t got;
        tcsb_res_t want;
        got.x_sum   = m_tdata[ACC_BITS-1:0];
        got.y_sum   = m_tdata[ACC_BITS +: ACC_BITS];
        got.bin_col = m_tdata[2*ACC_BITS +: OUT_IDX_BITS];
        got.bin_row = m_tdata[2*ACC_BITS+OUT_IDX_BITS +: OUT_IDX_BITS];
        got.last    = m_tlast;
        results_seen++;
        if (awaited_bins.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected bin (%0d,%0d)", got.bin_col, got.bin_row));
        end
        else
        begin
            want = awaited_bins.pop_front();
            if (got.x_sum !== want.x_sum)
                flag_mismatch($sformatf("bin (%0d,%0d) x_sum %0d, expected %0d",
                    want.bin_col, want.bin_row, $signed(got.x_sum), $signed(want.x_sum)));
            if (got.y_sum !== want.y_sum)
                flag_mismatch($sformatf("bin (%0d,%0d) y_sum %0d, expected %0d",
                    want.bin_col, want.bin_row, $signed(got.y_sum), $signed(want.y_sum)));
            if (got.bin_col !== want.bin_col)
                flag_mismatch($sformatf("bin_column %0d, expected %0d",
                    got.bin_col, want.bin_col));
            if (got.bin_row !== want.bin_row)
                flag_mismatch($sformatf("bin_row %0d, expected %0d",
                    got.bin_row, want.bin_row));
            if (got.last !== want.last)
                flag_mismatch($sformatf("bin (%0d,%0d) last_of_frame %b, expected %b",
                    want.bin_col, want.bin_row, got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = FRAME_BITS'(FRAME_RESET);
            height_reg   = FRAME_BITS'(FRAME_RESET);
            bin_reg      = BIN_BITS'(BIN_RESET);
            segment_x    = '0;
            segment_y    = '0;
            at_column    = 0;
            at_row       = 0;
            awaited_bins.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  width_reg  = cfg_wdata[FRAME_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata[FRAME_BITS-1:0];
                    REG_BIN_FACTOR:   bin_reg    = cfg_wdata[BIN_BITS-1:0];
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
                bin_pixel(s_tdata[SAMPLE_BITS-1:0], s_tdata[SAMPLE_BITS +: SAMPLE_BITS],
                          s_tuser);
            if (m_tvalid && m_tready)
                compare_bin();
            pending = awaited_bins.size();
        end
    end

endmodule

`default_nettype wire

/* tb/sv/two_channel_spatial_binning_tb.sv */
// Testbench top for the two-channel spatial binning block: stimulus and verdict.
`default_nettype none

// The top drives pixels into the block and configures it; the checker beside
// it follows both streams and the register writes, works out every binned
// result and compares it. The run goes as follows:
//   - a short directed part: pass-through at the reset settings with extreme
//     and patterned samples, a frame with a leftover column and row, a frame
//     that wraps without a start flag, registers written as zero and above
//     their range, and a frame narrower than one bin;
//   - a row with a width register above the maximum, which must act as the
//     maximum and so never wrap, and a short run with an oversized height;
//   - random settings, mostly small frames and small bins so that results
//     come often, with whole frames, frames cut short, frames restarted in
//     the middle and frames that carry on without a start flag;
//   - a last stretch with neither input gaps nor output stalls.
// Registers are only written once the block has drained, and every new
// setting starts with a start-of-frame pixel so that the column store is
// never read before it has been written.
module two_channel_spatial_binning_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_BIN       = 16;
    localparam int SAMPLE_BITS   = 24;
    localparam int IN_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 200;
    // Pipeline latency plus the result queue, with some margin.
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_NS   = 20_000_000;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [IN_TDATA_BITS-1:0]     s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [OUT_TDATA_BITS-1:0]    m_tdata;
    logic                         m_tlast;
    logic                         cfg_we;
    logic [CFG_ADDR_BITS-1:0]     cfg_addr;
    logic [CFG_DATA_BITS-1:0]     cfg_wdata;

    int fail_count;
    int pending;
    int results_seen;

    // Idling is switched off for the closing stretch; input gaps are also
    // switched per setting so that some settings run back to back.
    bit steady_tail;
    bit input_gaps;
    int pixels_sent;
    int settings_used;

    two_channel_spatial_binning #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_BIN     (MAX_BIN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    two_channel_spatial_binning_checker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_BIN     (MAX_BIN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Every task below is entered and left at a falling edge. Inputs change
    // there and the block samples them at the following rising edge.
    task automatic send_pixel(input logic [SAMPLE_BITS-1:0] xs,
                              input logic [SAMPLE_BITS-1:0] ys,
                              input logic sof);
        if (!steady_tail && input_gaps && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'({ys, xs});
        s_tuser  <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        pixels_sent++;
    endtask

    // A run of pixels; the start flag goes on the pixel numbered sof_at, so a
    // negative value sends a run without one. Style 0 uses extreme samples.
    task automatic send_run(input int count, input int sof_at, input int style);
        logic [SAMPLE_BITS-1:0] xs;
        logic [SAMPLE_BITS-1:0] ys;
        for (int i = 0; i < count; i++)
        begin
            if (style == 0)
            begin
                xs = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                ys = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            end
            else
            begin
                xs = SAMPLE_BITS'($urandom());
                ys = SAMPLE_BITS'($urandom());
            end
            send_pixel(xs, ys, i == sof_at);
        end
    endtask

    // Holds the input back until every awaited bin has come out, then gives
    // the pipeline time to finish pixels that close no bin.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_BITS'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned width_raw, input int unsigned height_raw,
                             input int unsigned bin_raw);
        drain();
        write_reg(REG_FRAME_WIDTH, width_raw);
        write_reg(REG_FRAME_HEIGHT, height_raw);
        write_reg(REG_BIN_FACTOR, bin_raw);
        settings_used++;
    endtask

    // One random setting followed by a few frames of mixed shape. Most
    // settings use small bins and frames; a few take bins up to the maximum.
    // A width or height of zero is written as it stands and acts as one.
    task automatic random_setting();
        int unsigned n, w, h, n_raw, area, frames, kind, style, pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            n = 1;
        else if (pick < 18)
            n = $urandom_range(2, 5);
        else
            n = $urandom_range(6, MAX_BIN);
        if (n > 5)
        begin
            w = n * $urandom_range(1, 2) + $urandom_range(0, n - 1);
            h = n + $urandom_range(0, 3);
        end
        else
        begin
            w = n * $urandom_range(0, 4) + $urandom_range(0, n - 1);
            h = n * $urandom_range(0, 3) + $urandom_range(0, n - 1);
        end
        n_raw = n;
        if (n == 1 && $urandom_range(0, 2) == 0)
            n_raw = 0;
        else if (n == MAX_BIN && $urandom_range(0, 1) == 0)
            n_raw = $urandom_range(MAX_BIN + 1, (1 << BIN_BITS) - 1);
        configure(w, h, n_raw);
        area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        style = $urandom_range(0, 3);
        input_gaps = ($urandom_range(0, 3) != 0);
        frames = (n > 5) ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            kind = $urandom_range(0, 9);
            // The first frame of a setting always opens with the start flag.
            if (f == 0 || kind < 6)
                send_run(area, 0, style);
            else if (kind < 8)
                send_run($urandom_range(1, area), 0, style);
            else if (kind == 8)
                send_run(area, -1, style);
            else
                send_run(area, $urandom_range(0, area - 1), style);
        end
    endtask

    // Output stalls in bursts, except in the closing stretch.
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!steady_tail && $urandom_range(0, 11) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d bins still awaited.", pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int random_start;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        steady_tail   = 1'b0;
        input_gaps    = 1'b1;
        pixels_sent   = 0;
        settings_used = 1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings pass every pixel through; the second start flag
        // restarts the frame in the middle of the first row.
        send_pixel(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_pixel(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_pixel('0, '0, 1'b0);
        send_pixel('1, '1, 1'b0);
        send_pixel({(SAMPLE_BITS/2){2'b01}}, {(SAMPLE_BITS/2){2'b10}}, 1'b1);
        send_pixel({(SAMPLE_BITS/2){2'b10}}, {(SAMPLE_BITS/2){2'b01}}, 1'b0);

        // Three by three with bins of two leaves a column and a row over.
        // The second frame carries on without a start flag.
        configure(3, 3, 2);
        for (int i = 0; i < 9; i++)
            send_pixel(SAMPLE_MAX, SAMPLE_MIN, i == 0);
        send_run(9, -1, 0);

        // Zero in every register acts as one: each pixel is a whole frame.
        configure(0, 0, 0);
        send_run(3, 0, 1);

        // A bin factor above the maximum on a one-pixel frame closes no bin,
        // and a write to the unused index must leave the settings alone.
        configure(1, 1, (1 << BIN_BITS) - 1);
        write_reg(REG_SPARE, $urandom());
        send_run(2, 0, 0);

        // A width above the maximum acts as the maximum: a row of single
        // pixel bins runs on along the first row without wrapping.
        configure($urandom_range(MAX_WIDTH + 1, (1 << FRAME_BITS) - 1), 1, 1);
        send_run(40, 0, 1);

        // The same for the height, on a narrow frame.
        configure(3, $urandom_range(MAX_WIDTH + 1, (1 << FRAME_BITS) - 1), 2);
        send_run(30, 0, 1);

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS)
            random_setting();

        // Closing stretch at full rate on both sides.
        drain();
        steady_tail = 1'b1;
        random_setting();

        drain();
        $display("Sent %0d pixels under %0d register settings; %0d binned results compared.",
                 pixels_sent, settings_used, results_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
